FILE: hdl/bti_pkg.sv
// Shared types, constants and helpers of the bilinear table interpolator.
`default_nettype none
package bti_pkg;

  localparam int unsigned MaxAxisPoints = 16;
  localparam int unsigned ValueBits     = 32;
  localparam int unsigned FracBits      = 16;
  localparam int unsigned AxisBits      = 4;
  localparam int unsigned CountBits     = 5;
  localparam int unsigned GridAddrBits  = 2 * AxisBits;

  // Function codes of an input word
  typedef enum logic [1:0] {
    FUNC_WR_X    = 2'd0,
    FUNC_WR_Y    = 2'd1,
    FUNC_WR_GRID = 2'd2,
    FUNC_LOOKUP  = 2'd3
  } func_e;

  // Configuration register indexes
  localparam logic CFG_X_POINTS = 1'b0;
  localparam logic CFG_Y_POINTS = 1'b1;

  typedef struct packed {
    logic [1:0]                  func;
    logic [AxisBits-1:0]         row_index;
    logic [AxisBits-1:0]         col_index;
    logic signed [ValueBits-1:0] write_value;
    logic signed [ValueBits-1:0] query_x;
    logic signed [ValueBits-1:0] query_y;
  } in_word_t;

  typedef struct packed {
    logic signed [ValueBits-1:0] interp_value;
    logic [AxisBits-1:0]         x_segment;
    logic [AxisBits-1:0]         y_segment;
    logic                        saturated;
  } out_word_t;

  // Point count limited to 2..MaxAxisPoints
  function automatic logic [CountBits-1:0] clamp_points(input logic [CountBits-1:0] r);
    logic [CountBits-1:0] n;
    if (r < CountBits'(2)) begin
      n = CountBits'(2);
    end else if (r > CountBits'(MaxAxisPoints)) begin
      n = CountBits'(MaxAxisPoints);
    end else begin
      n = r;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/bti_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
`default_nettype none
module bti_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32,
  parameter int unsigned AddrBits = $clog2(Depth)
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [Width-1:0]    wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: hdl/bti_frac_div.sv
// Restoring divider: floor(num * 2^FracBits / den) for num <= den, one bit a cycle.
`default_nettype none
module bti_frac_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [32:0] num_i,
  input  wire logic [32:0] den_i,
  output logic             done_o,
  output logic [bti_pkg::FracBits:0] quo_o
);

  localparam int unsigned CntBits = $clog2(bti_pkg::FracBits + 1);

  logic                     busy_q, done_q;
  logic [CntBits-1:0]       cnt_q;
  logic [33:0]              rem_q;
  logic [32:0]              den_q;
  logic [bti_pkg::FracBits:0] quo_q;
  logic [33:0]              trial;
  logic                     fits;

  // First step takes the integer bit without a shift
  assign trial = (cnt_q == '0) ? rem_q : {rem_q[32:0], 1'b0};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CntBits'(bti_pkg::FracBits));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntBits'(bti_pkg::FracBits)) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + CntBits'(1);
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
      quo_q <= {quo_q[bti_pkg::FracBits-1:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

FILE: hdl/bilinear_table_interpolator_unit.sv
// Top level of the bilinear table interpolator.
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one word per item.
//   Func codes write an X breakpoint, a Y breakpoint or a grid cell, or start
//   a lookup. Writes produce no output word.
//   A lookup searches the X axis, then the Y axis, each through its breakpoint
//   RAM one entry per cycle, runs a serial fraction division for a point
//   inside a segment, reads the four corners from the grid RAM and blends them
//   with one shared multiplier.
//   The lookup time depends on the breakpoint scan (one RAM read per
//   breakpoint) and the serial divider.
//   One lookup is in flight at a time; the next word is accepted once the
//   current lookup has loaded the output register.
//   Output channel (out_valid_o/out_ready_i/out_data_o) is a register: a
//   stalled receiver holds the result while new words are taken; a lookup
//   that finishes while the register is still full waits for it.
//   Config port writes point counts; write only while idle.
//   Reset clears control state and sets both point counts to 2; the tables
//   hold nothing defined until written.
`default_nettype none
module bilinear_table_interpolator_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire bti_pkg::in_word_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output bti_pkg::out_word_t       out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [bti_pkg::CountBits-1:0] cfg_wdata_i
);

  localparam int unsigned VB = bti_pkg::ValueBits;
  localparam int unsigned FB = bti_pkg::FracBits;
  localparam int unsigned AB = bti_pkg::AxisBits;
  localparam int unsigned CB = bti_pkg::CountBits;
  localparam int unsigned GB = bti_pkg::GridAddrBits;
  localparam int unsigned WB = FB + 1;          // weight width
  localparam int unsigned DB = VB + 2;          // blend difference width
  localparam int unsigned PB = DB + WB + 1;     // product width
  localparam int unsigned SB = VB + 4;          // blend sum width
  localparam logic [FB:0] FracOne = {1'b1, {FB{1'b0}}};
  localparam logic AxisX = 1'b0;
  localparam logic AxisY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LAST, ST_FIRST, ST_SCAN, ST_DIV, ST_GRID,
    ST_BL0, ST_BL1, ST_BL2, ST_BL3, ST_BL4
  } state_e;

  state_e state_q;
  logic [CB-1:0] xpts_q, ypts_q, nx_q, ny_q;
  logic signed [VB-1:0] qx_q, qy_q, prev_q;
  logic axis_q;
  logic [AB-1:0] idx_q, xs_q, ys_q;
  logic [FB:0] fx_q, fy_q;
  logic [2:0] gk_q;
  logic signed [VB-1:0] g_q [4];
  logic signed [DB-1:0] r0_q, r1_q;
  logic signed [PB-1:0] prod_q;
  logic out_valid_q, out_valid_d;
  bti_pkg::out_word_t out_q;

  logic in_acc;
  logic [AB-1:0] ax_raddr;
  logic [GB-1:0] g_raddr;
  logic [VB-1:0] xrd, yrd, grd;
  logic signed [VB-1:0] ax_data, cur_pt;
  logic [CB-1:0] cur_n;
  logic [AB-1:0] last_idx;
  logic hit, ax_done, div_done, div_start;
  logic [AB-1:0] done_seg;
  logic [FB:0] done_frac, quo;
  logic [32:0] num_w, den_w;
  logic slot_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // Current axis view
  assign ax_data  = (axis_q == AxisY) ? $signed(yrd) : $signed(xrd);
  assign cur_pt   = (axis_q == AxisY) ? qy_q : qx_q;
  assign cur_n    = (axis_q == AxisY) ? ny_q : nx_q;
  assign last_idx = AB'(cur_n - CB'(1));
  assign hit      = (cur_pt >= prev_q) && (cur_pt < ax_data);
  assign num_w    = 33'(33'(ax_data) - 33'(cur_pt));
  assign den_w    = 33'(33'(ax_data) - 33'(prev_q));
  assign div_start = (state_q == ST_SCAN) && hit;

  // Axis search outcome in this cycle
  always_comb begin
    ax_done   = 1'b0;
    done_seg  = '0;
    done_frac = '0;
    case (state_q)
      ST_LAST: begin
        if (cur_pt >= ax_data) begin
          ax_done   = 1'b1;
          done_seg  = AB'(cur_n - CB'(2));
          done_frac = FracOne;
        end
      end
      ST_FIRST: begin
        if (cur_pt <= ax_data) begin
          ax_done = 1'b1;
        end
      end
      ST_SCAN: begin
        if (!hit && idx_q == last_idx) begin
          ax_done = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ax_done   = 1'b1;
          done_seg  = idx_q - AB'(1);
          done_frac = FracOne - quo;
        end
      end
      default: ;
    endcase
  end

  // Breakpoint read address
  always_comb begin
    if (ax_done && axis_q == AxisX) begin
      ax_raddr = AB'(ny_q - CB'(1));
    end else begin
      case (state_q)
        ST_IDLE:  ax_raddr = AB'(bti_pkg::clamp_points(xpts_q) - CB'(1));
        ST_LAST:  ax_raddr = '0;
        ST_FIRST: ax_raddr = AB'(1);
        ST_SCAN:  ax_raddr = idx_q + AB'(1);
        default:  ax_raddr = '0;
      endcase
    end
  end

  // Grid corner read address
  always_comb begin
    case (gk_q)
      3'd0:    g_raddr = {xs_q, ys_q};
      3'd1:    g_raddr = {xs_q, ys_q + AB'(1)};
      3'd2:    g_raddr = {xs_q + AB'(1), ys_q};
      default: g_raddr = {xs_q + AB'(1), ys_q + AB'(1)};
    endcase
  end

  bti_ram #(.Depth(bti_pkg::MaxAxisPoints), .Width(VB)) u_xram (
    .clk_i,
    .we_i    (in_acc && in_data_i.func == bti_pkg::FUNC_WR_X),
    .waddr_i (in_data_i.row_index),
    .wdata_i (in_data_i.write_value),
    .raddr_i (ax_raddr),
    .rdata_o (xrd)
  );

  bti_ram #(.Depth(bti_pkg::MaxAxisPoints), .Width(VB)) u_yram (
    .clk_i,
    .we_i    (in_acc && in_data_i.func == bti_pkg::FUNC_WR_Y),
    .waddr_i (in_data_i.col_index),
    .wdata_i (in_data_i.write_value),
    .raddr_i (ax_raddr),
    .rdata_o (yrd)
  );

  bti_ram #(.Depth(bti_pkg::MaxAxisPoints * bti_pkg::MaxAxisPoints), .Width(VB)) u_gram (
    .clk_i,
    .we_i    (in_acc && in_data_i.func == bti_pkg::FUNC_WR_GRID),
    .waddr_i ({in_data_i.row_index, in_data_i.col_index}),
    .wdata_i (in_data_i.write_value),
    .raddr_i (g_raddr),
    .rdata_o (grd)
  );

  bti_frac_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .num_i   (num_w),
    .den_i   (den_w),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Shared multiplier operands
  logic signed [DB-1:0] mul_a;
  logic signed [WB:0]   mul_b;
  logic signed [PB-1:0] prod_w;
  logic signed [SB-1:0] blend_s, base_s;

  always_comb begin
    case (state_q)
      ST_BL0:  mul_a = DB'(g_q[1]) - DB'(g_q[0]);
      ST_BL1:  mul_a = DB'(g_q[3]) - DB'(g_q[2]);
      default: mul_a = r1_q - r0_q;
    endcase
    mul_b = (state_q == ST_BL3) ? $signed({1'b0, fx_q}) : $signed({1'b0, fy_q});
    case (state_q)
      ST_BL1:  base_s = SB'(g_q[0]);
      ST_BL2:  base_s = SB'(g_q[2]);
      default: base_s = SB'(r0_q);
    endcase
  end
  assign prod_w  = mul_a * mul_b;
  assign blend_s = base_s + SB'(prod_q >>> FB);

  // Output valid: cleared on handshake, set when a result loads
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (state_q == ST_BL4 && slot_free) out_valid_d = 1'b1;
  end

  // Control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      xpts_q      <= CB'(2);
      ypts_q      <= CB'(2);
      axis_q      <= AxisX;
      gk_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == bti_pkg::CFG_X_POINTS) xpts_q <= cfg_wdata_i;
        if (cfg_index_i == bti_pkg::CFG_Y_POINTS) ypts_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;

      case (state_q)
        ST_IDLE: begin
          if (in_acc && in_data_i.func == bti_pkg::FUNC_LOOKUP) begin
            state_q <= ST_LAST;
            axis_q  <= AxisX;
          end
        end
        ST_LAST, ST_FIRST, ST_SCAN, ST_DIV: begin
          if (ax_done) begin
            if (axis_q == AxisX) begin
              axis_q  <= AxisY;
              state_q <= ST_LAST;
            end else begin
              gk_q    <= '0;
              state_q <= ST_GRID;
            end
          end else if (state_q == ST_LAST) begin
            state_q <= ST_FIRST;
          end else if (state_q == ST_FIRST) begin
            state_q <= ST_SCAN;
          end else if (div_start) begin
            state_q <= ST_DIV;
          end
        end
        ST_GRID: begin
          gk_q <= gk_q + 3'd1;
          if (gk_q == 3'd4) state_q <= ST_BL0;
        end
        ST_BL0: state_q <= ST_BL1;
        ST_BL1: state_q <= ST_BL2;
        ST_BL2: state_q <= ST_BL3;
        ST_BL3: state_q <= ST_BL4;
        ST_BL4: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      qx_q <= in_data_i.query_x;
      qy_q <= in_data_i.query_y;
      nx_q <= bti_pkg::clamp_points(xpts_q);
      ny_q <= bti_pkg::clamp_points(ypts_q);
    end
    if (state_q == ST_FIRST) begin
      prev_q <= ax_data;
      idx_q  <= AB'(1);
    end else if (state_q == ST_SCAN && !hit) begin
      prev_q <= ax_data;
      idx_q  <= idx_q + AB'(1);
    end
    if (ax_done) begin
      if (axis_q == AxisX) begin
        xs_q <= done_seg;
        fx_q <= done_frac;
      end else begin
        ys_q <= done_seg;
        fy_q <= done_frac;
      end
    end
    if (state_q == ST_GRID && gk_q != 3'd0) begin
      g_q[gk_q[1:0] - 2'd1] <= $signed(grd);
    end
    if (state_q == ST_BL0 || state_q == ST_BL1 || state_q == ST_BL3) begin
      prod_q <= prod_w;
    end
    if (state_q == ST_BL1) r0_q <= DB'(blend_s);
    if (state_q == ST_BL2) r1_q <= DB'(blend_s);
    if (state_q == ST_BL4 && slot_free) begin
      out_q.x_segment <= xs_q;
      out_q.y_segment <= ys_q;
      if (blend_s[SB-1:VB-1] != '0 && blend_s[SB-1:VB-1] != '1) begin
        out_q.saturated    <= 1'b1;
        out_q.interp_value <= blend_s[SB-1] ? {1'b1, {(VB-1){1'b0}}}
                                            : {1'b0, {(VB-1){1'b1}}};
      end else begin
        out_q.saturated    <= 1'b0;
        out_q.interp_value <= blend_s[VB-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: hdl/bti_checker.sv
// Port-level checks of the interpolator, bound to the top level.
`default_nettype none
module bti_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire bti_pkg::in_word_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire bti_pkg::out_word_t out_data_o,
  input wire logic               cfg_we_i,
  input wire logic               cfg_index_i,
  input wire logic [bti_pkg::CountBits-1:0] cfg_wdata_i
);

  // Result word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // An accepted lookup closes the input in the next cycle
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.func == bti_pkg::FUNC_LOOKUP |=> !in_ready_o)
    else $error("input open right after lookup");

  // A table write leaves the block ready
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.func != bti_pkg::FUNC_LOOKUP |=> in_ready_o)
    else $error("write did not complete in one cycle");

  // Segment indexes never reach 15, which lies past the last segment of a full table
  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.x_segment != '1 && out_data_o.y_segment != '1)
    else $error("segment index out of range");

endmodule

bind bilinear_table_interpolator_unit bti_checker u_bti_checker (.*);
`default_nettype wire
